// File: hdl/gbhp_pkg.sv
// ----------------------------------------------------------------------------
// gbhp_pkg: shared types and constants of the blocked-gzip header parser
// Phase, status and format codes, header constants and the result word.
// ----------------------------------------------------------------------------
`default_nettype none

package gbhp_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned EXTRA_KEEP_BYTES_DEF = 12;
  localparam int unsigned POSITION_BITS_DEF    = 16;

  // Extra payload bytes the classifier looks at
  localparam int unsigned CLS_BYTES = 8;

  // Fixed header bytes
  localparam logic [7:0] GZ_ID1            = 8'h1f;
  localparam logic [7:0] GZ_ID2            = 8'h8b;
  localparam logic [7:0] GZ_CM_DEFLATE     = 8'h08;
  localparam logic [7:0] GZ_FLG_RSVD_MASK  = 8'hE0;
  localparam logic [7:0] GZ_NUL            = 8'h00;
  localparam int unsigned FLG_FHCRC_BIT    = 1;
  localparam int unsigned FLG_FEXTRA_BIT   = 2;
  localparam int unsigned FLG_FNAME_BIT    = 3;
  localparam int unsigned FLG_FCOMMENT_BIT = 4;
  // Position of the last of the six fixed bytes (MTIME, XFL, OS)
  localparam int unsigned FIXED_LAST_POS   = 9;
  localparam logic [3:0]  XOFF_PRESENT     = 4'd12;

  // Subfield signatures, first four payload bytes, little-endian
  localparam logic [31:0] SIG_BC    = 32'h0002_4342;
  localparam logic [31:0] SIG_MZ    = 32'h0004_5a4d;
  localparam logic [31:0] SIG_IG_V1 = 32'h0010_4749;
  localparam logic [31:0] SIG_IG_V2 = 32'h0004_4749;
  localparam logic [7:0]  SIG_7D    = 8'h7d;
  localparam logic [15:0] XLEN_BC   = 16'd6;
  localparam logic [15:0] XLEN_MZ   = 16'd8;
  localparam logic [15:0] XLEN_IG1  = 16'd20;
  localparam logic [15:0] XLEN_IG2  = 16'd8;
  localparam logic [15:0] XLEN_7D   = 16'd4;
  localparam logic [31:0] MZ_BIAS   = 32'd8;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_MAGIC  = 3'd1,
    ST_BAD_METHOD = 3'd2,
    ST_TRUNCATED  = 3'd3,
    ST_UNKNOWN    = 3'd4,
    ST_TOO_LONG   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    FMT_NONE  = 3'd0,
    FMT_BC    = 3'd1,
    FMT_MZ    = 3'd2,
    FMT_IG_V1 = 3'd3,
    FMT_IG_V2 = 3'd4,
    FMT_7D    = 3'd5
  } format_e;

  typedef enum logic [13:0] {
    PH_MAGIC0   = 14'b00_0000_0000_0001,
    PH_MAGIC1   = 14'b00_0000_0000_0010,
    PH_METHOD   = 14'b00_0000_0000_0100,
    PH_FLAGS    = 14'b00_0000_0000_1000,
    PH_FIXED    = 14'b00_0000_0001_0000,
    PH_XLEN0    = 14'b00_0000_0010_0000,
    PH_XLEN1    = 14'b00_0000_0100_0000,
    PH_XDATA    = 14'b00_0000_1000_0000,
    PH_NAME     = 14'b00_0001_0000_0000,
    PH_COMMENT  = 14'b00_0010_0000_0000,
    PH_HCRC0    = 14'b00_0100_0000_0000,
    PH_HCRC1    = 14'b00_1000_0000_0000,
    PH_DONE     = 14'b01_0000_0000_0000,
    PH_CLASSIFY = 14'b10_0000_0000_0000
  } phase_e;

  // First payload bytes, byte i at index i
  typedef logic [CLS_BYTES-1:0][7:0] head_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_final;
  } in_word_t;

  typedef struct packed {
    status_e     status;
    format_e     format;
    logic [31:0] block_length;
  } cls_t;

  typedef struct packed {
    status_e     status;
    format_e     format;
    logic [15:0] header_length;
    logic [3:0]  extra_offset;
    logic [15:0] extra_length;
    logic [31:0] block_length;
  } res_t;

endpackage

`default_nettype wire

// File: hdl/gbhp_in_if.sv
// ----------------------------------------------------------------------------
// gbhp_in_if: byte input channel
// Valid/ready channel carrying one buffer byte and its last-byte mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_final;

  modport source (output valid, output data_byte, output is_final, input ready);
  modport sink   (input valid, input data_byte, input is_final, output ready);
endinterface

`default_nettype wire

// File: hdl/gbhp_out_if.sv
// ----------------------------------------------------------------------------
// gbhp_out_if: result channel
// Valid/ready channel carrying one parsed header result.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbhp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [2:0]  format;
  logic [15:0] header_length;
  logic [3:0]  extra_offset;
  logic [15:0] extra_length;
  logic [31:0] block_length;

  modport source (output valid, output status, output format, output header_length,
                  output extra_offset, output extra_length, output block_length,
                  input ready);
  modport sink   (input valid, input status, input format, input header_length,
                  input extra_offset, input extra_length, input block_length,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/gbhp_classify.sv
// ----------------------------------------------------------------------------
// gbhp_classify: extra subfield classifier
// Matches the extra payload against the blocked-gzip signatures and forms
// the block length modulo 2^32.
// ----------------------------------------------------------------------------
`default_nettype none

module gbhp_classify import gbhp_pkg::*; #(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
  input  head_t                    head_i,
  input  logic [15:0]              xlen_i,
  input  logic [POSITION_BITS-1:0] pos_i,
  output cls_t                     cls_o
);

  logic [31:0] word0;
  logic [31:0] word1;

  assign word0 = head_i[3:0];
  assign word1 = head_i[7:4];

  // Pick the first signature that matches, in priority order
  always_comb begin
    cls_o.status       = ST_OK;
    cls_o.format       = FMT_NONE;
    cls_o.block_length = '0;
    if (xlen_i == XLEN_BC && word0 == SIG_BC) begin
      cls_o.format       = FMT_BC;
      cls_o.block_length = {16'h0000, head_i[5], head_i[4]} + 32'd1;
    end else if (xlen_i == XLEN_MZ && word0 == SIG_MZ) begin
      cls_o.format       = FMT_MZ;
      cls_o.block_length = word1 + 32'(pos_i) + MZ_BIAS;
    end else if (xlen_i == XLEN_IG1 && word0 == SIG_IG_V1) begin
      cls_o.format       = FMT_IG_V1;
      cls_o.block_length = word1;
    end else if (xlen_i == XLEN_IG2 && word0 == SIG_IG_V2) begin
      cls_o.format       = FMT_IG_V2;
      cls_o.block_length = word1;
    end else if (xlen_i == XLEN_7D && head_i[3] == SIG_7D) begin
      cls_o.format       = FMT_7D;
      cls_o.block_length = {8'h00, word0[23:0]};
    end else begin
      cls_o.status = ST_UNKNOWN;
    end
  end

endmodule

`default_nettype wire

// File: hdl/gbhp_parse_core.sv
// ----------------------------------------------------------------------------
// gbhp_parse_core: header phase tracker
// Advances the parse phase by one byte per step, keeps the extra payload
// head and decides the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module gbhp_parse_core import gbhp_pkg::*; #(
  parameter int unsigned EXTRA_KEEP_BYTES = EXTRA_KEEP_BYTES_DEF,
  parameter int unsigned POSITION_BITS    = POSITION_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     adv_i,
  input  in_word_t word_i,
  output logic     emit_o,
  output res_t     res_o
);

  localparam int unsigned IDX_W = $clog2(EXTRA_KEEP_BYTES);

  phase_e                   ph_q, ph_d, ph_n;
  logic [POSITION_BITS-1:0] pos_q, pos_d, pos_cur;
  logic [4:1]               flg_q, flg_d, flg_n;
  logic [15:0]              xlen_q, xlen_d, xlen_n;
  logic [15:0]              seen_q, seen_d, seen_n;
  logic                     known_q, known_d, known_n;
  logic                     given_q, given_d;
  logic [7:0]               store_q [EXTRA_KEEP_BYTES];

  logic    pos_full;
  logic    step;
  logic    wr_en;
  logic    err;
  status_e err_st;
  logic [7:0] b;
  head_t   head;
  cls_t    cls;
  logic    next_xdata_hit;
  phase_e  nx_xdata, nx_name, nx_comment;

  assign b        = word_i.data_byte;
  assign pos_full = (pos_q == '1);
  assign step     = !given_q && !pos_full;

  // Phase that follows each optional section
  always_comb begin
    nx_comment = flg_q[FLG_FHCRC_BIT] ? PH_HCRC0 : PH_CLASSIFY;
    nx_name    = flg_q[FLG_FCOMMENT_BIT] ? PH_COMMENT : nx_comment;
    nx_xdata   = flg_q[FLG_FNAME_BIT] ? PH_NAME : nx_name;
  end

  assign next_xdata_hit = ((seen_q + 16'd1) >= xlen_q);

  // Advance the phase on one byte
  always_comb begin
    ph_n    = ph_q;
    pos_cur = pos_q;
    flg_n   = flg_q;
    xlen_n  = xlen_q;
    known_n = known_q;
    seen_n  = seen_q;
    wr_en   = 1'b0;
    err     = 1'b0;
    err_st  = ST_OK;
    if (step) begin
      pos_cur = pos_q + 1'b1;
      unique case (ph_q)
        PH_MAGIC0: begin
          if (b != GZ_ID1) begin
            err    = 1'b1;
            err_st = ST_BAD_MAGIC;
          end else begin
            ph_n = PH_MAGIC1;
          end
        end
        PH_MAGIC1: begin
          if (b != GZ_ID2) begin
            err    = 1'b1;
            err_st = ST_BAD_MAGIC;
          end else begin
            ph_n = PH_METHOD;
          end
        end
        PH_METHOD: begin
          if (b != GZ_CM_DEFLATE) begin
            err    = 1'b1;
            err_st = ST_BAD_METHOD;
          end else begin
            ph_n = PH_FLAGS;
          end
        end
        PH_FLAGS: begin
          flg_n = b[4:1];
          if ((b & GZ_FLG_RSVD_MASK) != '0) begin
            err    = 1'b1;
            err_st = ST_BAD_METHOD;
          end else if (!b[FLG_FEXTRA_BIT]) begin
            err    = 1'b1;
            err_st = ST_UNKNOWN;
          end else begin
            ph_n = PH_FIXED;
          end
        end
        PH_FIXED: begin
          if (pos_q >= POSITION_BITS'(FIXED_LAST_POS)) ph_n = PH_XLEN0;
        end
        PH_XLEN0: begin
          xlen_n = {8'h00, b};
          ph_n   = PH_XLEN1;
        end
        PH_XLEN1: begin
          xlen_n  = {b, xlen_q[7:0]};
          known_n = 1'b1;
          seen_n  = '0;
          ph_n    = ({b, xlen_q[7:0]} != '0) ? PH_XDATA : nx_xdata;
        end
        PH_XDATA: begin
          wr_en  = (seen_q < 16'(EXTRA_KEEP_BYTES));
          seen_n = seen_q + 16'd1;
          if (next_xdata_hit) ph_n = nx_xdata;
        end
        PH_NAME: begin
          if (b == GZ_NUL) ph_n = nx_name;
        end
        PH_COMMENT: begin
          if (b == GZ_NUL) ph_n = nx_comment;
        end
        PH_HCRC0: begin
          ph_n = PH_HCRC1;
        end
        default: begin
          ph_n = PH_CLASSIFY;
        end
      endcase
    end
  end

  // Present the payload head as it stands after this byte
  always_comb begin
    for (int i = 0; i < CLS_BYTES; i++) begin
      head[i] = (wr_en && seen_q == 16'(i)) ? b : store_q[i];
    end
  end

  gbhp_classify #(
    .POSITION_BITS (POSITION_BITS)
  ) u_classify (
    .head_i (head),
    .xlen_i (xlen_n),
    .pos_i  (pos_cur),
    .cls_o  (cls)
  );

  // Decide the result and the next state
  always_comb begin
    emit_o              = 1'b0;
    res_o.status        = ST_OK;
    res_o.format        = FMT_NONE;
    res_o.block_length  = '0;
    res_o.header_length = 16'(pos_cur);
    res_o.extra_offset  = flg_n[FLG_FEXTRA_BIT] ? XOFF_PRESENT : 4'd0;
    res_o.extra_length  = known_n ? xlen_n : 16'd0;
    if (!given_q) begin
      if (pos_full) begin
        emit_o       = 1'b1;
        res_o.status = ST_TOO_LONG;
      end else if (err) begin
        emit_o       = 1'b1;
        res_o.status = err_st;
      end else if (ph_n == PH_CLASSIFY) begin
        emit_o             = 1'b1;
        res_o.status       = cls.status;
        res_o.format       = cls.format;
        res_o.block_length = cls.block_length;
      end else if (word_i.is_final) begin
        emit_o = 1'b1;
        if ((ph_n == PH_NAME || ph_n == PH_COMMENT) && !flg_n[FLG_FHCRC_BIT]) begin
          res_o.status       = cls.status;
          res_o.format       = cls.format;
          res_o.block_length = cls.block_length;
        end else begin
          res_o.status = ST_TRUNCATED;
        end
      end
    end

    ph_d    = emit_o ? PH_DONE : ph_n;
    pos_d   = pos_cur;
    flg_d   = flg_n;
    xlen_d  = xlen_n;
    seen_d  = seen_n;
    known_d = known_n;
    given_d = given_q || emit_o;
    // Re-arm on the last byte of a buffer
    if (word_i.is_final) begin
      ph_d    = PH_MAGIC0;
      pos_d   = '0;
      flg_d   = '0;
      xlen_d  = '0;
      seen_d  = '0;
      known_d = 1'b0;
      given_d = 1'b0;
    end
  end

  // Hold parse state; advance only on a taken byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= PH_MAGIC0;
      pos_q   <= '0;
      flg_q   <= '0;
      xlen_q  <= '0;
      seen_q  <= '0;
      known_q <= 1'b0;
      given_q <= 1'b0;
    end else if (adv_i) begin
      ph_q    <= ph_d;
      pos_q   <= pos_d;
      flg_q   <= flg_d;
      xlen_q  <= xlen_d;
      seen_q  <= seen_d;
      known_q <= known_d;
      given_q <= given_d;
    end
  end

  // Keep the first payload bytes
  always_ff @(posedge clk_i) begin
    if (adv_i && wr_en) begin
      store_q[seen_q[IDX_W-1:0]] <= b;
    end
  end

endmodule

`default_nettype wire

// File: hdl/gzip_block_header_parser.sv
// Path: a result word passes the input register, then the parse and result
//   register, after its byte is taken.
// Throughput: one byte per cycle unless a result waits on a full output.
//   Phase update and decision: combinational, input to result register.
// Reset: rst_ni clears the channel valids and the parse state; the parser
//   then waits for the first magic byte.
// ----------------------------------------------------------------------------
// gzip_block_header_parser: blocked-gzip member header parser
// Registers the incoming word, steps the header parser and holds the result
// word until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module gzip_block_header_parser import gbhp_pkg::*; #(
  parameter int unsigned EXTRA_KEEP_BYTES = EXTRA_KEEP_BYTES_DEF,
  parameter int unsigned POSITION_BITS    = POSITION_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  gbhp_in_if.sink           byte_i,
  gbhp_out_if.source        result_o
);

  logic     in_valid_q;
  in_word_t in_q;
  logic     out_valid_q;
  res_t     out_q;
  logic     emit;
  res_t     res;
  logic     out_free;
  logic     adv;

  // Step the parser unless its result has nowhere to go
  assign out_free     = !out_valid_q || result_o.ready;
  assign adv          = in_valid_q && (!emit || out_free);
  assign byte_i.ready = !in_valid_q || adv;

  // Capture the incoming word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (byte_i.valid && byte_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      in_q.data_byte <= byte_i.data_byte;
      in_q.is_final  <= byte_i.is_final;
    end
  end

  gbhp_parse_core #(
    .EXTRA_KEEP_BYTES (EXTRA_KEEP_BYTES),
    .POSITION_BITS    (POSITION_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .word_i (in_q),
    .emit_o (emit),
    .res_o  (res)
  );

  // Hold the result word until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && emit) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      out_q <= res;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.status        = out_q.status;
  assign result_o.format        = out_q.format;
  assign result_o.header_length = out_q.header_length;
  assign result_o.extra_offset  = out_q.extra_offset;
  assign result_o.extra_length  = out_q.extra_length;
  assign result_o.block_length  = out_q.block_length;

endmodule

`default_nettype wire

// File: sim/gbhp_header_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gbhp_header_checker: result predictor and scoreboard for the header parser
// Watches both channels, steps its own copy of the header parser on every
// accepted byte word and compares each accepted result word with the oldest
// predicted header result.
// ----------------------------------------------------------------------------

module gbhp_header_checker import gbhp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  gbhp_in_if          byte_mon_i,
  gbhp_out_if         result_mon_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output logic [7:0]  status_seen_o,
  output logic [7:0]  format_seen_o
);

  // Parser state as the block should hold it
  phase_e      ph;
  logic [15:0] pos;
  logic [7:0]  flg;
  logic [15:0] xlen;
  logic [15:0] xseen;
  logic        xlen_known;
  logic        done_r;
  logic [7:0]  xhead [EXTRA_KEEP_BYTES_DEF];

  res_t        header_results_q [$];
  res_t        want;
  int unsigned mismatches;
  int unsigned checked;
  logic [7:0]  st_seen;
  logic [7:0]  fm_seen;

  // Return to the first magic byte for a new buffer
  function automatic void rearm_parser();
    ph         = PH_MAGIC0;
    pos        = '0;
    flg        = '0;
    xlen       = '0;
    xseen      = '0;
    xlen_known = 1'b0;
    done_r     = 1'b0;
  endfunction

  // Queue one header result built from the current parse state
  function automatic void post_result(status_e st, format_e fm, logic [31:0] blk);
    res_t r;
    r.status        = st;
    r.format        = fm;
    r.header_length = pos;
    r.extra_offset  = flg[FLG_FEXTRA_BIT] ? XOFF_PRESENT : 4'd0;
    r.extra_length  = xlen_known ? xlen : 16'd0;
    r.block_length  = blk;
    header_results_q.push_back(r);
    done_r = 1'b1;
    ph     = PH_DONE;
  endfunction

  function automatic logic [31:0] head_word(int unsigned at);
    return {xhead[at + 3], xhead[at + 2], xhead[at + 1], xhead[at]};
  endfunction

  // Pick the next optional header field the flags still ask for
  function automatic phase_e next_after(phase_e from);
    if (from < PH_NAME && flg[FLG_FNAME_BIT]) return PH_NAME;
    if (from < PH_COMMENT && flg[FLG_FCOMMENT_BIT]) return PH_COMMENT;
    if (from < PH_HCRC0 && flg[FLG_FHCRC_BIT]) return PH_HCRC0;
    return PH_CLASSIFY;
  endfunction

  // Match the kept extra payload against the known subfield signatures
  function automatic void classify_header();
    logic [31:0] w0;
    logic [31:0] w4;
    w0 = head_word(0);
    w4 = head_word(4);
    if (xlen == XLEN_BC && w0 == SIG_BC)
      post_result(ST_OK, FMT_BC, {16'd0, w4[15:0]} + 32'd1);
    else if (xlen == XLEN_MZ && w0 == SIG_MZ)
      post_result(ST_OK, FMT_MZ, w4 + {16'd0, pos} + MZ_BIAS);
    else if (xlen == XLEN_IG1 && w0 == SIG_IG_V1)
      post_result(ST_OK, FMT_IG_V1, w4);
    else if (xlen == XLEN_IG2 && w0 == SIG_IG_V2)
      post_result(ST_OK, FMT_IG_V2, w4);
    else if (xlen == XLEN_7D && w0[31:24] == SIG_7D)
      post_result(ST_OK, FMT_7D, {8'd0, w0[23:0]});
    else
      post_result(ST_UNKNOWN, FMT_NONE, 32'd0);
  endfunction

  // Step the parser by one byte; a final byte always re-arms it
  function automatic void parse_header_byte(logic [7:0] b, logic fin);
    logic [15:0] at;
    if (!done_r) begin
      if (pos == '1) begin
        post_result(ST_TOO_LONG, FMT_NONE, 32'd0);
      end else begin
        at  = pos;
        pos = pos + 16'd1;
        case (ph)
          PH_MAGIC0: if (b != GZ_ID1) post_result(ST_BAD_MAGIC, FMT_NONE, 32'd0);
                     else ph = PH_MAGIC1;
          PH_MAGIC1: if (b != GZ_ID2) post_result(ST_BAD_MAGIC, FMT_NONE, 32'd0);
                     else ph = PH_METHOD;
          PH_METHOD: if (b != GZ_CM_DEFLATE) post_result(ST_BAD_METHOD, FMT_NONE, 32'd0);
                     else ph = PH_FLAGS;
          PH_FLAGS: begin
            flg = b;
            if ((b & GZ_FLG_RSVD_MASK) != 8'd0) post_result(ST_BAD_METHOD, FMT_NONE, 32'd0);
            else if (!b[FLG_FEXTRA_BIT]) post_result(ST_UNKNOWN, FMT_NONE, 32'd0);
            else ph = PH_FIXED;
          end
          PH_FIXED: if (at >= FIXED_LAST_POS) ph = PH_XLEN0;
          PH_XLEN0: begin
            xlen = {8'd0, b};
            ph   = PH_XLEN1;
          end
          PH_XLEN1: begin
            xlen[15:8] = b;
            xlen_known = 1'b1;
            xseen      = '0;
            ph         = (xlen != 16'd0) ? PH_XDATA : next_after(PH_XDATA);
          end
          PH_XDATA: begin
            if (xseen < EXTRA_KEEP_BYTES_DEF) xhead[xseen] = b;
            xseen = xseen + 16'd1;
            if (xseen >= xlen) ph = next_after(PH_XDATA);
          end
          PH_NAME:    if (b == GZ_NUL) ph = next_after(PH_NAME);
          PH_COMMENT: if (b == GZ_NUL) ph = next_after(PH_COMMENT);
          PH_HCRC0:   ph = PH_HCRC1;
          default:    ph = PH_CLASSIFY;
        endcase
        if (!done_r && ph == PH_CLASSIFY) classify_header();
        // Buffer ended undecided: a name or comment may run to the end
        if (!done_r && fin) begin
          if ((ph == PH_NAME || ph == PH_COMMENT) && !flg[FLG_FHCRC_BIT])
            classify_header();
          else
            post_result(ST_TRUNCATED, FMT_NONE, 32'd0);
        end
      end
    end
    if (fin) rearm_parser();
  endfunction

  function automatic void check_field(string fname, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // Predict on byte words, compare on result words
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rearm_parser();
      for (int i = 0; i < EXTRA_KEEP_BYTES_DEF; i++) xhead[i] = 8'd0;
      header_results_q.delete();
      mismatches    = 0;
      checked       = 0;
      st_seen       = '0;
      fm_seen       = '0;
      fail_count_o  <= 0;
      pending_o     <= 0;
      checked_o     <= 0;
      status_seen_o <= '0;
      format_seen_o <= '0;
    end else begin
      if (byte_mon_i.valid && byte_mon_i.ready)
        parse_header_byte(byte_mon_i.data_byte, byte_mon_i.is_final);
      if (result_mon_i.valid && result_mon_i.ready) begin
        if (header_results_q.size() == 0) begin
          $display("%0t: result word with no header result expected, status %0d",
                   $time, result_mon_i.status);
          mismatches++;
        end else begin
          want = header_results_q.pop_front();
          check_field("status", 32'(want.status), 32'(result_mon_i.status));
          check_field("format", 32'(want.format), 32'(result_mon_i.format));
          check_field("header_length", 32'(want.header_length),
                      32'(result_mon_i.header_length));
          check_field("extra_offset", 32'(want.extra_offset), 32'(result_mon_i.extra_offset));
          check_field("extra_length", 32'(want.extra_length), 32'(result_mon_i.extra_length));
          check_field("block_length", want.block_length, result_mon_i.block_length);
          checked++;
          st_seen[want.status] = 1'b1;
          fm_seen[want.format] = 1'b1;
        end
      end
      fail_count_o  <= mismatches;
      pending_o     <= header_results_q.size();
      checked_o     <= checked;
      status_seen_o <= st_seen;
      format_seen_o <= fm_seen;
    end
  end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the blocked-gzip member header parser
// Feeds byte buffers (directed error cases, random well-formed headers of
// every subfield format with random cuts and trailers, and noise) under
// varying valid/ready idling and a long receiver stall; the checker predicts
// and compares every result word.
// ----------------------------------------------------------------------------

module tb_top import gbhp_pkg::*; ();

  typedef logic [7:0] bytes_t [$];

  localparam logic [7:0]  FL_EXTRA   = 8'd1 << FLG_FEXTRA_BIT;
  localparam logic [7:0]  FL_NAME    = 8'd1 << FLG_FNAME_BIT;
  localparam int unsigned HOLD_LEN   = 400;

  logic        clk_i;
  logic        rst_ni;
  int unsigned src_idle_pct = 13;
  int unsigned snk_idle_pct = 86;
  logic        hold_on      = 1'b0;
  logic        hold_served;
  int unsigned hold_left;
  int unsigned bytes_sent   = 0;
  int unsigned buffers_sent = 0;

  int unsigned fail_count;
  int unsigned pending_results;
  int unsigned results_checked;
  logic [7:0]  status_seen;
  logic [7:0]  format_seen;

  gbhp_in_if  byte_if ();
  gbhp_out_if result_if ();

  gzip_block_header_parser dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_if),
    .result_o (result_if)
  );

  gbhp_header_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_mon_i    (byte_if),
    .result_mon_i  (result_if),
    .fail_count_o  (fail_count),
    .pending_o     (pending_results),
    .checked_o     (results_checked),
    .status_seen_o (status_seen),
    .format_seen_o (format_seen)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Receiver: random stalls, plus one long hold-off when asked
  initial begin
    hold_left   = 0;
    hold_served = 1'b0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        result_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_on && !hold_served) begin
        result_if.ready <= 1'b0;
        hold_left   = HOLD_LEN;
        hold_served = 1'b1;
      end else begin
        result_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Offer one byte word, idling at random first; hold valid until taken
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      byte_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= b;
    byte_if.is_final  <= last;
    do begin
      @(posedge clk_i);
    end while (!byte_if.ready);
    bytes_sent++;
  endtask

  task automatic send_buffer(input bytes_t bq);
    foreach (bq[i]) send_byte(bq[i], i == bq.size() - 1);
    buffers_sent++;
  endtask

  task automatic push_word(ref bytes_t q, input logic [31:0] w);
    for (int i = 0; i < 4; i++) q.push_back(w[8*i +: 8]);
  endtask

  // Zero-terminated name or comment
  task automatic add_text(ref bytes_t q);
    repeat ($urandom_range(6)) q.push_back(8'($urandom_range(255, 1)));
    q.push_back(GZ_NUL);
  endtask

  // Build a mostly well-formed header with a random extra subfield
  task automatic make_header(output bytes_t hq);
    bytes_t      xq;
    logic [7:0]  flg;
    logic [15:0] xl;
    int unsigned kind;
    hq = {};
    xq = {};
    hq.push_back(($urandom_range(39) == 0) ? 8'($urandom) : GZ_ID1);
    hq.push_back(($urandom_range(39) == 0) ? 8'($urandom) : GZ_ID2);
    hq.push_back(($urandom_range(29) == 0) ? 8'($urandom) : GZ_CM_DEFLATE);
    flg = 8'($urandom_range(31));
    flg[FLG_FEXTRA_BIT] = ($urandom_range(15) != 0);
    if ($urandom_range(24) == 0) flg[7:5] = 3'($urandom_range(7, 1));
    hq.push_back(flg);
    repeat (6) hq.push_back(8'($urandom));
    kind = $urandom_range(11);
    if (kind > 7) kind = $urandom_range(4);
    case (kind)
      0: begin
        push_word(xq, SIG_BC);
        repeat (2) xq.push_back(8'($urandom));
      end
      1: begin
        push_word(xq, SIG_MZ);
        push_word(xq, $urandom);
      end
      2: begin
        push_word(xq, SIG_IG_V1);
        repeat (4) push_word(xq, $urandom);
      end
      3: begin
        push_word(xq, SIG_IG_V2);
        push_word(xq, $urandom);
      end
      4: begin
        repeat (3) xq.push_back(8'($urandom));
        xq.push_back(SIG_7D);
      end
      5: begin
        // near miss: flip a signature bit or drop the last byte
        push_word(xq, $urandom_range(1) ? SIG_IG_V2 : SIG_MZ);
        push_word(xq, $urandom);
        if ($urandom_range(1)) xq[$urandom_range(3)] ^= 8'd1 << $urandom_range(7);
        else void'(xq.pop_back());
      end
      6: repeat ($urandom_range(24)) xq.push_back(8'($urandom));
      default: repeat ($urandom_range(16)) xq.push_back(8'($urandom));
    endcase
    // huge declared length: the buffer always ends inside the extra data
    if (kind == 7) xl = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom_range(65534, 100));
    else xl = 16'(xq.size());
    hq.push_back(xl[7:0]);
    hq.push_back(xl[15:8]);
    foreach (xq[i]) hq.push_back(xq[i]);
    if (flg[FLG_FNAME_BIT]) add_text(hq);
    if (flg[FLG_FCOMMENT_BIT]) add_text(hq);
    if (flg[FLG_FHCRC_BIT]) repeat (2) hq.push_back(8'($urandom));
  endtask

  // Random buffers: headers cut short, with trailers or exact; some noise
  task automatic run_traffic(input int unsigned upto);
    bytes_t      hq;
    int unsigned cut;
    while (bytes_sent < upto) begin
      if ($urandom_range(6) == 0) begin
        hq = {};
        if ($urandom_range(1)) begin
          hq.push_back(GZ_ID1);
          hq.push_back(GZ_ID2);
        end
        repeat ($urandom_range(8, 1)) hq.push_back(8'($urandom));
      end else begin
        make_header(hq);
        case ($urandom_range(9))
          0, 1: begin
            cut = $urandom_range(hq.size() - 1);
            while (hq.size() > cut + 1) void'(hq.pop_back());
          end
          2, 3: repeat ($urandom_range(4, 1)) hq.push_back(8'($urandom));
          default: ;
        endcase
      end
      send_buffer(hq);
    end
  endtask

  // Stimulus and verdict
  initial begin
    bytes_t hq;
    rst_ni             = 1'b0;
    byte_if.valid      = 1'b0;
    byte_if.data_byte  = 8'd0;
    byte_if.is_final   = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: each early decision, ignored trailer, name running to the end
    hq = {8'hFF};
    send_buffer(hq);
    hq = {GZ_ID1, 8'h00};
    send_buffer(hq);
    hq = {GZ_ID1, GZ_ID2, 8'hFF};
    send_buffer(hq);
    hq = {GZ_ID1, GZ_ID2, GZ_CM_DEFLATE, GZ_FLG_RSVD_MASK | FL_EXTRA};
    send_buffer(hq);
    hq = {GZ_ID1, GZ_ID2, GZ_CM_DEFLATE, 8'h00, 8'hFF};
    send_buffer(hq);
    hq = {GZ_ID1, GZ_ID2, GZ_CM_DEFLATE, FL_EXTRA};
    send_buffer(hq);
    hq = {GZ_ID1, GZ_ID2, GZ_CM_DEFLATE, FL_EXTRA | FL_NAME,
          8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF,
          XLEN_7D[7:0], XLEN_7D[15:8], 8'hFF, 8'hFF, 8'hFF, SIG_7D, 8'hFF};
    send_buffer(hq);

    run_traffic(520);

    // Receiver stalls long while one-byte buffers keep coming
    hold_on = 1'b1;
    repeat (24) send_byte(8'($urandom_range(30)), 1'b1);
    hold_on = 1'b0;

    // Pause until every result is back
    byte_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);

    src_idle_pct = 86;
    snk_idle_pct = 13;
    run_traffic(1040);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_traffic(1560);
    byte_if.valid <= 1'b0;

    // Drain, then allow for the output pipeline
    while (pending_results != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Run covered %0d bytes in %0d buffers, %0d header results checked",
             bytes_sent, buffers_sent, results_checked);
    $display("Status codes seen %b, formats seen %b, mismatches %0d",
             status_seen, format_seen, fail_count);
    if (fail_count == 0) begin
      $display("gzip_block_header_parser: match");
    end else begin
      $display("gzip_block_header_parser: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Timeout: %0d header results still outstanding", pending_results);
    $display("gzip_block_header_parser: mismatch");
    $finish;
  end

endmodule

// File: files.f
hdl/gbhp_pkg.sv
hdl/gbhp_in_if.sv
hdl/gbhp_out_if.sv
hdl/gbhp_classify.sv
hdl/gbhp_parse_core.sv
hdl/gzip_block_header_parser.sv
sim/gbhp_header_checker.sv
sim/tb_top.sv
